[rtl/rtsm_pkg.sv]
package rtsm_pkg;

  localparam int SCREEN_WIDTH  = 272;
  localparam int SCREEN_HEIGHT = 480;
  localparam int MARKER_SIZE   = 30;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [28:0] ID_LO = 29'h310;
  localparam logic [28:0] ID_HI = 29'h38F;

  // 1.5 m and 7.0 m expressed in quarter metres.
  localparam int ALARM_RADIUS_Q = 6;
  localparam int Y_RANGE_Q      = 28;

  // The marker row divides by the forward range through a scaled reciprocal.
  localparam int Y_RECIP_SH = 20;
  localparam int Y_RECIP    = (1 << Y_RECIP_SH) / Y_RANGE_Q + 1;

  localparam int X_MAX   = SCREEN_WIDTH - MARKER_SIZE;
  localparam int Y_MAX   = SCREEN_HEIGHT - MARKER_SIZE;
  localparam int BAR_MAX = 4095;

  localparam int X_NUM_A = 2 * SCREEN_WIDTH + 2;
  localparam int X_NUM_B = 5 * SCREEN_WIDTH;

  localparam int DIV_NW   = 22;
  localparam int DIV_DW   = 12;
  localparam int DIV_STEP = 2;
  localparam int DIV_CYC  = DIV_NW / DIV_STEP;
  localparam int DIV_CW   = $clog2(DIV_CYC + 1);

  localparam logic [CFG_W-1:0] RST_WARN      = 10'd50;
  localparam logic [CFG_W-1:0] RST_DANGER    = 10'd20;
  localparam logic [CFG_W-1:0] RST_VEHICLE   = 10'd30;
  localparam logic [CFG_W-1:0] RST_LAT_SAFE  = 10'd60;
  localparam logic [CFG_W-1:0] RST_LAT_WARN  = 10'd50;
  localparam logic [CFG_W-1:0] RST_LAT_DNGR  = 10'd30;
  localparam logic [CFG_W-1:0] RST_LAT_ALARM = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN      = 3'd0,
    CFG_DANGER    = 3'd1,
    CFG_VEHICLE   = 3'd2,
    CFG_LAT_SAFE  = 3'd3,
    CFG_LAT_WARN  = 3'd4,
    CFG_LAT_DNGR  = 3'd5,
    CFG_LAT_ALARM = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ZONE_SAFE   = 2'd0,
    ZONE_WARN   = 2'd1,
    ZONE_DANGER = 2'd2,
    ZONE_ALARM  = 2'd3
  } zone_t;

  localparam logic [3:0][15:0] ZONE_COLOUR = {16'd63488, 16'd64512, 16'd65504, 16'd2016};

  typedef struct packed {
    logic [CFG_W-1:0]        warn;
    logic [CFG_W-1:0]        danger;
    logic [CFG_W-1:0]        vehicle;
    logic [3:0][CFG_W-1:0]   lat;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               make_visible;
    logic [1:0]         zone;
    logic [15:0]        target_color;
    logic [7:0]         target_x_px;
    logic [8:0]         target_y_px;
    logic [11:0]        bar_width_px;
    logic signed [11:0] bar_left_px;
    logic [7:0]         radius_q;
    logic signed [7:0]  angle_deg;
    logic signed [7:0]  lateral_q;
    logic [7:0]         forward_q;
  } res_t;

endpackage

[rtl/rtsm_in_if.sv]
interface rtsm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [28:0] frame_id;
  logic [7:0]  radius_byte;
  logic [7:0]  angle_byte;
  logic [7:0]  forward_byte;
  logic [7:0]  lateral_byte;
  logic [7:0]  status_byte;

  modport source (output valid, kind, frame_id, radius_byte, angle_byte, forward_byte,
                  lateral_byte, status_byte, input ready);
  modport sink (input valid, kind, frame_id, radius_byte, angle_byte, forward_byte,
                lateral_byte, status_byte, output ready);
  modport mon (input valid, ready, kind, frame_id, radius_byte, angle_byte, forward_byte,
               lateral_byte, status_byte);
endinterface

[rtl/rtsm_out_if.sv]
interface rtsm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               make_visible;
  logic [1:0]         zone;
  logic [15:0]        target_color;
  logic [7:0]         target_x_px;
  logic [8:0]         target_y_px;
  logic [11:0]        bar_width_px;
  logic signed [11:0] bar_left_px;
  logic [7:0]         radius_q;
  logic signed [7:0]  angle_deg;
  logic signed [7:0]  lateral_q;
  logic [7:0]         forward_q;

  modport source (output valid, action, make_visible, zone, target_color, target_x_px,
                  target_y_px, bar_width_px, bar_left_px, radius_q, angle_deg, lateral_q,
                  forward_q, input ready);
  modport sink (input valid, action, make_visible, zone, target_color, target_x_px,
                target_y_px, bar_width_px, bar_left_px, radius_q, angle_deg, lateral_q,
                forward_q, output ready);
  modport mon (input valid, ready, action, make_visible, zone, target_color, target_x_px,
               target_y_px, bar_width_px, bar_left_px, radius_q, angle_deg, lateral_q,
               forward_q);
endinterface

[rtl/rtsm_cfg.sv]
module rtsm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtsm_pkg::CFG_W-1:0]     cfg_wdata,
  output rtsm_pkg::cfg_t                 cfg
);
  import rtsm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WARN:      cfg_nxt.warn    = cfg_wdata;
        CFG_DANGER:    cfg_nxt.danger  = cfg_wdata;
        CFG_VEHICLE:   cfg_nxt.vehicle = cfg_wdata;
        CFG_LAT_SAFE:  cfg_nxt.lat[0]  = cfg_wdata;
        CFG_LAT_WARN:  cfg_nxt.lat[1]  = cfg_wdata;
        CFG_LAT_DNGR:  cfg_nxt.lat[2]  = cfg_wdata;
        CFG_LAT_ALARM: cfg_nxt.lat[3]  = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn    <= RST_WARN;
      cfg_r.danger  <= RST_DANGER;
      cfg_r.vehicle <= RST_VEHICLE;
      cfg_r.lat     <= {RST_LAT_ALARM, RST_LAT_DNGR, RST_LAT_WARN, RST_LAT_SAFE};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/rtsm_div.sv]
module rtsm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rtsm_pkg::DIV_NW-1:0] num,
  input  logic [rtsm_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [rtsm_pkg::DIV_NW-1:0] quo
);
  import rtsm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   trial;

  // Restoring division, two quotient bits per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      for (int i = 0; i < DIV_STEP; i++) begin
        trial   = {rem_nxt, quo_nxt[DIV_NW-1]};
        quo_nxt = {quo_nxt[DIV_NW-2:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt    = DIV_DW'(trial - {1'b0, den_r});
          quo_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[DIV_DW-1:0];
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/radar_target_to_screen_mapper.sv]
// An input transfer is followed by two divisions by the lateral range, which run one after
// another on the shared divider before the result is loaded.
// One item is handled at a time; a new item is accepted in the cycle after the previous
// result is loaded, even if that result is still waiting.
// Reset (synchronous, active low) hides the target, loads the default registers and
// empties the output.
module radar_target_to_screen_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  rtsm_in_if.sink                        in_ch,
  rtsm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rtsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtsm_pkg::CFG_W-1:0]     cfg_wdata
);
  import rtsm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_OUT} state_t;
  typedef enum logic [1:0] {OP_X, OP_BAR} op_t;

  cfg_t cfg;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              shown_r, shown_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;
  logic              det_r, det_nxt;
  logic [1:0]        zone_r, zone_nxt;
  logic [CFG_W-1:0]  lr_r, lr_nxt;
  logic [7:0]        radius_r, radius_nxt;
  logic signed [7:0] angle_r, angle_nxt;
  logic signed [7:0] lat_r, lat_nxt;
  logic [7:0]        fwd_r, fwd_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [8:0]        y_r, y_nxt;
  logic [11:0]       bw_r, bw_nxt;

  logic              det;
  logic [11:0]       r5;
  logic [1:0]        zone_in;
  logic [CFG_W-1:0]  lr_sel;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic signed [22:0] x_num;
  logic [4:0]        y_k;
  logic [15:0]       y_n;
  logic [31:0]       y_prod;
  logic [11:0]       y_q;
  logic signed [13:0] bl_diff;

  rtsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rtsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign det = !in_ch.kind && (in_ch.frame_id >= ID_LO) && (in_ch.frame_id <= ID_HI)
               && !in_ch.status_byte[0];
  assign r5  = {2'b00, in_ch.radius_byte, 2'b00} + {4'b0000, in_ch.radius_byte};

  always_comb begin
    if (!det) begin
      zone_in = ZONE_SAFE;
    end else if (r5 > {1'b0, cfg.warn, 1'b0}) begin
      zone_in = ZONE_SAFE;
    end else if (r5 > {1'b0, cfg.danger, 1'b0}) begin
      zone_in = ZONE_WARN;
    end else if (in_ch.radius_byte > 8'(ALARM_RADIUS_Q)) begin
      zone_in = ZONE_DANGER;
    end else begin
      zone_in = ZONE_ALARM;
    end
  end

  assign lr_sel = cfg.lat[zone_in];

  // Operand for the shared divider, and the forward range term for the marker row.
  assign x_num = $signed(23'(lr_r) * 23'(X_NUM_A)) + 23'(lat_r) * $signed(23'(X_NUM_B));
  assign y_k   = (fwd_r <= 8'(Y_RANGE_Q)) ? 5'(8'(Y_RANGE_Q) - fwd_r) : 5'd0;

  assign y_n    = 16'(y_k * SCREEN_HEIGHT);
  assign y_prod = {16'b0, y_n} * 32'(Y_RECIP);
  assign y_q    = y_prod[Y_RECIP_SH +: 12];

  always_comb begin
    case (op_r)
      OP_X: begin
        div_num = x_num[22] ? '0 : x_num[DIV_NW-1:0];
        div_den = {lr_r, 2'b00};
      end
      OP_BAR: begin
        div_num = DIV_NW'(cfg.vehicle * SCREEN_WIDTH) + DIV_NW'(lr_r);
        div_den = {1'b0, lr_r, 1'b0};
      end
      default: begin
        div_num = '0;
        div_den = DIV_DW'(1);
      end
    endcase
  end

  assign bl_diff = $signed(14'(SCREEN_WIDTH + 1)) - $signed({2'b00, bw_r});

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    shown_nxt     = shown_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    det_nxt       = det_r;
    zone_nxt      = zone_r;
    lr_nxt        = lr_r;
    radius_nxt    = radius_r;
    angle_nxt     = angle_r;
    lat_nxt       = lat_r;
    fwd_nxt       = fwd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    bw_nxt        = bw_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          det_nxt    = det;
          zone_nxt   = zone_in;
          lr_nxt     = (lr_sel == '0) ? CFG_W'(1) : lr_sel;
          radius_nxt = in_ch.radius_byte;
          angle_nxt  = $signed(in_ch.angle_byte ^ 8'h80);
          lat_nxt    = $signed(in_ch.lateral_byte ^ 8'h80);
          fwd_nxt    = in_ch.forward_byte;
          op_nxt     = OP_X;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          case (op_r)
            OP_X: begin
              x_nxt  = (div_quo > DIV_NW'(X_MAX)) ? 8'(X_MAX) : div_quo[7:0];
              y_nxt  = (y_q > 12'(Y_MAX)) ? 9'(Y_MAX) : y_q[8:0];
              op_nxt = OP_BAR;
            end
            default: begin
              bw_nxt = (div_quo > DIV_NW'(BAR_MAX)) ? 12'(BAR_MAX) : div_quo[11:0];
            end
          endcase
          state_nxt = (op_r == OP_BAR) ? S_OUT : S_START;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          res_nxt = '0;
          if (det_r) begin
            res_nxt.action       = ACT_SHOW;
            res_nxt.make_visible = !shown_r;
            res_nxt.zone         = zone_r;
            res_nxt.target_color = ZONE_COLOUR[zone_r];
            res_nxt.target_x_px  = x_r;
            res_nxt.target_y_px  = y_r;
            res_nxt.bar_width_px = bw_r;
            res_nxt.bar_left_px  = 12'(bl_diff >>> 1);
            res_nxt.radius_q     = radius_r;
            res_nxt.angle_deg    = angle_r;
            res_nxt.lateral_q    = lat_r;
            res_nxt.forward_q    = fwd_r;
            shown_nxt            = 1'b1;
          end else if (shown_r) begin
            res_nxt.action       = ACT_CLEAR;
            res_nxt.bar_width_px = bw_r;
            res_nxt.bar_left_px  = 12'(bl_diff >>> 1);
            shown_nxt            = 1'b0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_X;
      shown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      shown_r     <= shown_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r    <= res_nxt;
    det_r    <= det_nxt;
    zone_r   <= zone_nxt;
    lr_r     <= lr_nxt;
    radius_r <= radius_nxt;
    angle_r  <= angle_nxt;
    lat_r    <= lat_nxt;
    fwd_r    <= fwd_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    bw_r     <= bw_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = res_r.action;
  assign out_ch.make_visible = res_r.make_visible;
  assign out_ch.zone         = res_r.zone;
  assign out_ch.target_color = res_r.target_color;
  assign out_ch.target_x_px  = res_r.target_x_px;
  assign out_ch.target_y_px  = res_r.target_y_px;
  assign out_ch.bar_width_px = res_r.bar_width_px;
  assign out_ch.bar_left_px  = res_r.bar_left_px;
  assign out_ch.radius_q     = res_r.radius_q;
  assign out_ch.angle_deg    = res_r.angle_deg;
  assign out_ch.lateral_q    = res_r.lateral_q;
  assign out_ch.forward_q    = res_r.forward_q;

endmodule

[rtl/rtsm_chk.sv]
module rtsm_chk (
  input logic        clk,
  input logic        rst_n,
  rtsm_in_if.sink    in_ch,
  rtsm_out_if.source out_ch
);
  import rtsm_pkg::*;

  // A stalled result holds its action.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.action))
    else $error("result changed while stalled");

  // One item at a time: the block is busy right after an input transfer.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is in progress");

  // Only a shown target carries marker fields.
  a_no_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action != ACT_SHOW |->
      out_ch.target_x_px == 8'd0 && out_ch.target_color == 16'd0 && out_ch.zone == 2'd0)
    else $error("marker fields set without a shown target");

  // An idle result carries no bar geometry.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_NONE |->
      out_ch.bar_width_px == 12'd0 && out_ch.bar_left_px == 12'sd0)
    else $error("bar geometry set on an empty result");

endmodule

bind radar_target_to_screen_mapper rtsm_chk u_rtsm_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
